// File: sv/mme_pkg.sv
// Shared constants, register indexes and sequencer types for the Montgomery exponentiation core.
package mme_pkg;

  localparam int WORD_BITS = 32;
  localparam int DBL_BITS  = 2 * WORD_BITS;
  localparam int IDX_BITS  = 2;

  localparam logic [IDX_BITS-1:0] REG_MODULUS      = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_EXPONENT     = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_MONT_INVERSE = 2'd2;
  localparam logic [IDX_BITS-1:0] REG_R_SQUARED    = 2'd3;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [DBL_BITS-1:0]  dword_t;

  // Phases of one Montgomery product on the shared multiplier.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_RED_M,
    S_RED_MN,
    S_RED_SUB,
    S_FIX,
    S_OUT
  } state_t;

  // Which product of the exponentiation is in flight.
  typedef enum logic [2:0] {
    OP_BASE_IN,
    OP_ACC_IN,
    OP_ACC_MUL,
    OP_BASE_SQ,
    OP_FINAL
  } op_t;

endpackage

// File: sv/montgomery_modular_exponentiation_core.sv
// Top level: Montgomery modular exponentiation on one word with a shared multiplier.
//
// Usage: write modulus, exponent, mont_inverse and r_squared through the cfg_ channel
// (index 0 to 3, always ready) while the core is idle. Each item on in_ carries one
// message word; one item on out_ returns message^exponent mod modulus.
// Every Montgomery product runs as five steps on the single 32x32 multiplier: the
// operand product, m = T*inverse, m*N, a 64-bit subtract with borrow, and the final
// add-back of N. An item needs 3 + popcount(exponent) + bitlength(exponent) products.
// in_tready is high only while the sequencer is idle; one item is worked on at a time.
// The result sits in an output register; while the receiver stalls, the next item is
// still accepted and computed, and only its delivery waits for the register to free.
// Synchronous reset clears the sequencer and the output valid and sets the
// registers to modulus 1, exponent 0, mont_inverse 1 and r_squared 0.
module montgomery_modular_exponentiation_core
  import mme_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [31:0]         in_tdata,   // [31:0] message
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata,  // [31:0] power_result
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [31:0]         cfg_data
);

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  word_t  modulus_r, exponent_r, inverse_r, r_squared_r;
  word_t  e_r, e_nxt;
  word_t  base_r, base_nxt;
  word_t  acc_r, acc_nxt;
  dword_t t_r, t_nxt;
  word_t  m_r, m_nxt;
  dword_t mn_r, mn_nxt;
  word_t  x_r, x_nxt;
  logic   brw_r, brw_nxt;
  logic   out_valid_r, out_valid_nxt;
  word_t  out_data_r, out_data_nxt;

  word_t  mul_a, mul_b;
  dword_t mul_p;
  logic [DBL_BITS:0] sub_w;
  word_t  x_fix;
  word_t  e_shift;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Operand selection for the one shared multiplier.
  always_comb begin
    mul_a = t_r[WORD_BITS-1:0];
    mul_b = inverse_r;
    case (state_r)
      S_MUL: begin
        case (op_r)
          OP_BASE_IN: begin mul_a = base_r;      mul_b = r_squared_r; end
          OP_ACC_IN:  begin mul_a = r_squared_r; mul_b = word_t'(1);  end
          OP_ACC_MUL: begin mul_a = acc_r;       mul_b = base_r;      end
          OP_BASE_SQ: begin mul_a = base_r;      mul_b = base_r;      end
          OP_FINAL:   begin mul_a = acc_r;       mul_b = word_t'(1);  end
          default:    begin mul_a = acc_r;       mul_b = word_t'(1);  end
        endcase
      end
      S_RED_MN: begin
        mul_a = m_r;
        mul_b = modulus_r;
      end
      default: begin
        mul_a = t_r[WORD_BITS-1:0];
        mul_b = inverse_r;
      end
    endcase
  end

  assign mul_p   = dword_t'(mul_a) * dword_t'(mul_b);
  assign sub_w   = {1'b0, t_r} - {1'b0, mn_r};
  assign x_fix   = brw_r ? word_t'(x_r + modulus_r) : x_r;
  assign e_shift = e_r >> 1;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    e_nxt         = e_r;
    base_nxt      = base_r;
    acc_nxt       = acc_r;
    t_nxt         = t_r;
    m_nxt         = m_r;
    mn_nxt        = mn_r;
    x_nxt         = x_r;
    brw_nxt       = brw_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          base_nxt  = in_tdata;
          e_nxt     = exponent_r;
          op_nxt    = OP_BASE_IN;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        t_nxt     = mul_p;
        state_nxt = S_RED_M;
      end
      S_RED_M: begin
        m_nxt     = mul_p[WORD_BITS-1:0];
        state_nxt = S_RED_MN;
      end
      S_RED_MN: begin
        mn_nxt    = mul_p;
        state_nxt = S_RED_SUB;
      end
      S_RED_SUB: begin
        x_nxt     = sub_w[DBL_BITS-1:WORD_BITS];
        brw_nxt   = sub_w[DBL_BITS];
        state_nxt = S_FIX;
      end
      S_FIX: begin
        state_nxt = S_MUL;
        case (op_r)
          OP_BASE_IN: begin
            base_nxt = x_fix;
            op_nxt   = OP_ACC_IN;
          end
          OP_ACC_IN: begin
            acc_nxt = x_fix;
            if (e_r == '0) begin
              op_nxt = OP_FINAL;
            end else if (e_r[0]) begin
              op_nxt = OP_ACC_MUL;
            end else begin
              op_nxt = OP_BASE_SQ;
            end
          end
          OP_ACC_MUL: begin
            acc_nxt = x_fix;
            op_nxt  = OP_BASE_SQ;
          end
          OP_BASE_SQ: begin
            base_nxt = x_fix;
            e_nxt    = e_shift;
            if (e_shift == '0) begin
              op_nxt = OP_FINAL;
            end else if (e_shift[0]) begin
              op_nxt = OP_ACC_MUL;
            end else begin
              op_nxt = OP_BASE_SQ;
            end
          end
          OP_FINAL: begin
            acc_nxt   = x_fix;
            state_nxt = S_OUT;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_OUT: begin
        // Wait here until the output register is free.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = acc_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_BASE_IN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r   <= word_t'(1);
      exponent_r  <= '0;
      inverse_r   <= word_t'(1);
      r_squared_r <= '0;
      e_r         <= '0;
    end else begin
      e_r <= e_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODULUS:      modulus_r   <= cfg_data;
          REG_EXPONENT:     exponent_r  <= cfg_data;
          REG_MONT_INVERSE: inverse_r   <= cfg_data;
          REG_R_SQUARED:    r_squared_r <= cfg_data;
          default:          ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    base_r     <= base_nxt;
    acc_r      <= acc_nxt;
    t_r        <= t_nxt;
    m_r        <= m_nxt;
    mn_r       <= mn_nxt;
    x_r        <= x_nxt;
    brw_r      <= brw_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef NO_ASSERTIONS
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("output valid rose outside the delivery state");

  a_exp_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIX && op_r == OP_BASE_SQ) |=> (e_r == ($past(e_r) >> 1)))
    else $error("exponent did not shift after a squaring");

  a_final_exp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (op_r == OP_FINAL && state_r != S_IDLE) |-> (e_r == '0))
    else $error("final reduction started with exponent bits left");

  a_red_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RED_SUB) |-> $past(state_r == S_RED_MN))
    else $error("reduction phases out of order");
`endif

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the Montgomery modular exponentiation core.
module testbench
  import mme_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HANG_LIMIT   = 3000;
  localparam int SETTLE_TIME  = 400;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 75;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [31:0]         in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [31:0]         out_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IDX_BITS-1:0] cfg_index = REG_MODULUS;
  logic [31:0]         cfg_data = '0;

  // Register copies, as the core holds them after reset.
  word_t key_modulus  = 32'd1;
  word_t key_exponent = 32'd0;
  word_t key_inverse  = 32'd1;
  word_t key_rsq      = 32'd0;

  word_t message_q[$];
  word_t power_q[$];
  int    fail_count = 0;
  int    sender_idle_pct = 0;
  int    receiver_stall_pct = 0;
  int    quiet_cycles = 0;

  montgomery_modular_exponentiation_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // One Montgomery reduction of a double-width value, with the add-back of N.
  function automatic word_t mont_redc(dword_t t);
    word_t  m;
    dword_t mn;
    dword_t diff;
    word_t  x;
    m    = word_t'(t[WORD_BITS-1:0] * key_inverse);
    mn   = dword_t'(m) * dword_t'(key_modulus);
    diff = t - mn;
    x    = diff[DBL_BITS-1:WORD_BITS];
    if (t < mn) begin
      x = x + key_modulus;
    end
    return x;
  endfunction

  function automatic word_t modexp_predict(word_t msg);
    word_t base;
    word_t acc;
    word_t e;
    base = mont_redc(dword_t'(msg) * dword_t'(key_rsq));
    acc  = mont_redc(dword_t'(key_rsq));
    e    = key_exponent;
    while (e != 0) begin
      if (e[0]) begin
        acc = mont_redc(dword_t'(acc) * dword_t'(base));
      end
      base = mont_redc(dword_t'(base) * dword_t'(base));
      e    = e >> 1;
    end
    return mont_redc(dword_t'(acc));
  endfunction

  // Newton iteration for N^-1 mod 2^32; valid for odd N only.
  function automatic word_t inverse_of(word_t n);
    word_t v;
    v = n;
    repeat (5) v = v * (32'd2 - n * v);
    return v;
  endfunction

  function automatic word_t rsq_of(word_t n);
    logic [DBL_BITS:0] r;
    r = '0;
    r[DBL_BITS] = 1'b1;
    return word_t'(r % {33'd0, n});
  endfunction

  function automatic word_t pick_message(word_t n);
    case ($urandom_range(9))
      0: return $urandom;
      1: return '0;
      2: return n - 32'd1;
      default: return (n == 0) ? word_t'($urandom) : word_t'($urandom % n);
    endcase
  endfunction

  task automatic set_reg(input logic [IDX_BITS-1:0] idx, input word_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODULUS:      key_modulus  = value;
      REG_EXPONENT:     key_exponent = value;
      REG_MONT_INVERSE: key_inverse  = value;
      REG_R_SQUARED:    key_rsq      = value;
      default: ;
    endcase
  endtask

  task automatic load_key(input word_t n, input word_t e, input word_t inv, input word_t r2);
    set_reg(REG_MODULUS, n);
    set_reg(REG_EXPONENT, e);
    set_reg(REG_MONT_INVERSE, inv);
    set_reg(REG_R_SQUARED, r2);
    cfg_valid <= 1'b0;
  endtask

  // Every item yields one result, so empty message and result queues mean the core is idle.
  task automatic drain;
    while (message_q.size() != 0 || power_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_profile(input int mode);
    case (mode)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 48; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 48; end
      default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
    endcase
  endtask

  // Driver: holds an item until it is taken, then predicts its result.
  always @(posedge clk) begin : driver
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (in_tvalid && in_tready) begin
        power_q.push_back(modexp_predict(in_tdata));
        void'(message_q.pop_front());
      end
      if (message_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= message_q[0];
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    word_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (power_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected result %h with nothing outstanding", out_tdata);
          end
        end else begin
          want = power_q.pop_front();
          if (out_tdata !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("power_result mismatch: expected %h, got %h", want, out_tdata);
            end
          end
        end
      end
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
        $display("testbench failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : sequencer
    word_t n;
    word_t e;
    word_t inv;
    word_t r2;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers still at their reset values.
    set_profile(0);
    message_q.push_back(32'h0000_0000);
    message_q.push_back(32'hFFFF_FFFF);
    drain;

    // Largest odd modulus with a full exponent.
    load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, inverse_of(32'hFFFF_FFFF), rsq_of(32'hFFFF_FFFF));
    message_q.push_back(32'h0000_0000);
    message_q.push_back(32'h0000_0001);
    message_q.push_back(32'hFFFF_FFFE);
    message_q.push_back(32'hFFFF_FFFF);
    message_q.push_back(32'hAAAA_AAAA);
    message_q.push_back(32'h5555_5555);
    drain;

    // Exponent zero, with messages below and above the modulus.
    set_profile(3);
    load_key(32'd3, 32'd0, inverse_of(32'd3), rsq_of(32'd3));
    message_q.push_back(32'd0);
    message_q.push_back(32'd2);
    message_q.push_back(32'hFFFF_FFFF);
    drain;

    load_key(32'h8000_0001, 32'd65537, inverse_of(32'h8000_0001), rsq_of(32'h8000_0001));
    message_q.push_back(32'h1234_5678);
    message_q.push_back(32'h7FFF_FFFF);
    drain;

    load_key(32'd1, 32'd1, 32'd1, 32'd0);
    message_q.push_back(32'hDEAD_BEEF);
    drain;

    // Even modulus, zero inverse and a bogus R squared: the datapath runs regardless.
    load_key(32'h0000_1000, 32'h0000_F0F0, 32'h0000_0000, 32'hFFFF_FFFF);
    message_q.push_back(32'd1);
    message_q.push_back(32'hCAFE_F00D);
    drain;

    load_key(32'd0, 32'd3, 32'hFFFF_FFFF, 32'h0001_2345);
    message_q.push_back(32'd7);
    drain;

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(3))
        0: n = $urandom_range(255, 3) | 32'd1;
        1: n = $urandom | 32'h8000_0001;
        default: n = $urandom | 32'd1;
      endcase
      case ($urandom_range(5))
        0: e = $urandom_range(15);
        1: e = '1;
        2: e = $urandom >> $urandom_range(31);
        default: e = $urandom;
      endcase
      inv = inverse_of(n);
      r2  = rsq_of(n);
      // Now and then a broken key, to exercise the unchecked datapath.
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(2))
          0: inv = $urandom;
          1: r2 = $urandom;
          default: n = n ^ 32'd1;
        endcase
      end
      set_profile(ph % 4);
      load_key(n, e, inv, r2);
      repeat (PHASE_ITEMS) message_q.push_back(pick_message(key_modulus));
      drain;
    end

    repeat (SETTLE_TIME) @(posedge clk);
    if (power_q.size() != 0) begin
      fail_count += power_q.size();
      $display("%0d results never arrived", power_q.size());
    end
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
